@@ rtl/core/acr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types and constants of the allpass/comb reverberator.
// ----------------------------------------------------------------------------
package acr_pkg;

	// default sizes
	localparam int DEF_MAX_DELAY   = 8192;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_CHANNELS    = 2;

	// register file
	localparam int NUM_LINES = 7;
	localparam int NUM_AP    = 3;
	localparam int LINE_W    = 3;
	localparam int DLY_W     = 13;
	localparam int GAIN_W    = 15;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 15;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(7);

	localparam logic [DLY_W-1:0] DLY_RESET [NUM_LINES] = '{
		13'd347, 13'd113, 13'd37, 13'd1687, 13'd1601, 13'd2053, 13'd2251
	};
	localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd20316;

	// gain digit size of the serial multiplier
	localparam int DIG_W = 4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WAIT,
		ST_MULX,
		ST_MULD,
		ST_UPD,
		ST_DONE
	} acr_state_t;

endpackage

@@ rtl/core/acr_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acr_mul
// Digit-serial multiplier of a sample by a Q0.15 gain, rounded result.
// ----------------------------------------------------------------------------
module acr_mul import acr_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] operand,
	input  logic [GAIN_W-1:0]             gain,
	output logic                          done,
	output logic signed [SAMPLE_BITS+1:0] product
);

	localparam int NDIG  = (GAIN_W + DIG_W - 1) / DIG_W;
	localparam int GP_W  = NDIG * DIG_W;
	localparam int ACC_W = SAMPLE_BITS + GP_W + 1;
	localparam int PP_W  = SAMPLE_BITS + DIG_W + 1;
	localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [SAMPLE_BITS-1:0] opnd_q;
	logic [GP_W-1:0]               gsh_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PP_W-1:0]        pp;
	logic signed [ACC_W-1:0]       rnd;

	// partial product of one gain digit
	assign pp = opnd_q * $signed({1'b0, gsh_q[GP_W-1 -: DIG_W]});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	// accumulate most significant digit first
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			gsh_q  <= GP_W'(gain);
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< DIG_W) + ACC_W'(pp);
			gsh_q <= gsh_q << DIG_W;
		end
	end

	// round half up and drop the fraction
	assign rnd     = (acc_q + ACC_W'(16384)) >>> 15;
	assign product = rnd[SAMPLE_BITS+1:0];
	assign done    = done_q;

endmodule

@@ rtl/core/allpass_comb_reverb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allpass_comb_reverb
// Three series allpass stages and four averaged feed-forward comb taps per
// channel, all lines in one shared sample memory.
// ----------------------------------------------------------------------------
// Usage
//   Input beats (channel_in, sample_in) are taken on in_valid with in_stall
//   low. One result beat (channel_out, sample_out) is given per input beat,
//   in order, on out_valid and held while out_stall is high.
//   An item passes each allpass stage in read, read wait, two gain products
//   and write, and each comb tap in read, read wait, one product and write,
//   plus one final step; a gain product takes four digit steps in the
//   digit-serial multiplier before it raises done.
//   in_stall is high while an item is in work; the next item is taken once
//   the previous one has been moved into the output register, so the block
//   does not take a new item before the last is through, and a stalled
//   receiver holds back the next item only at its final step.
//   The user must write registers over the cfg channel (cfg_ready is always
//   high) while the block is idle, not enforced; unknown indexes are ignored.
//   Reset restores the default delays and gain and clears the write
//   positions and per-channel fill counts. Memory entries not yet written
//   since reset read as zero through the fill count; no clearing pass.
// ----------------------------------------------------------------------------
module allpass_comb_reverb import acr_pkg::*; #(
	parameter int MAX_DELAY   = DEF_MAX_DELAY,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int CHANNELS    = DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          channel_in,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          channel_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int AW     = $clog2(MAX_DELAY);
	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_AW = LINE_W + CW + AW;
	localparam int SB     = SAMPLE_BITS;
	localparam int EW     = SB + 3;
	localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
	localparam logic [AW:0] MAXD = (AW + 1)'(MAX_DELAY);

	function automatic logic signed [SB-1:0] sat_s(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI;
		else if (v < SAT_LO)
			r = SAT_LO;
		else
			r = v;
		return r[SB-1:0];
	endfunction

	acr_state_t state_q, state_d;

	logic [DLY_W-1:0]    dly_q [NUM_LINES];
	logic [GAIN_W-1:0]   gain_q;
	logic [AW-1:0]       wp_q  [CHANNELS];
	logic [AW:0]         cnt_q [CHANNELS];

	logic [CW-1:0]       ch_q;
	logic                chin_q;
	logic [LINE_W-1:0]   k_q;
	logic signed [SB-1:0]   x_q;
	logic signed [SB-1:0]   d_q;
	logic signed [SB+1:0]   mx_q;
	logic signed [SB+1:0]   sum_q;
	logic                vld_q;
	logic                out_valid_q;
	logic                chout_q;
	logic signed [SB-1:0]   sout_q;

	logic [SB-1:0]       mem [0:(1 << MEM_AW)-1];
	logic signed [SB-1:0]   rdata_q;

	logic                accept;
	logic                out_free;
	logic                is_ap;
	logic                last_line;
	logic [CW-1:0]       ch_map;
	logic [31:0]         dly32;
	logic [AW-1:0]       dm;
	logic [AW:0]         deff;
	logic [AW-1:0]       rpos;
	logic [MEM_AW-1:0]   raddr;
	logic [MEM_AW-1:0]   waddr;
	logic signed [SB-1:0]   d_gated;
	logic signed [SB-1:0]   ap_y;
	logic signed [SB-1:0]   ap_w;
	logic signed [SB-1:0]   cb_t;
	logic signed [SB+1:0]   sum_sh;

	logic                rd_en;
	logic                wr_en;
	logic                mul_start;
	logic                mul_sel_d;
	logic signed [SB-1:0]   mul_opnd;
	logic                mul_done;
	logic signed [SB+1:0]   mul_p;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign is_ap     = (k_q < LINE_W'(NUM_AP));
	assign last_line = (k_q == LINE_W'(NUM_LINES - 1));
	assign cfg_ready = 1'b1;

	// channel beyond the configured count folds onto the last one
	assign ch_map = (32'(channel_in) >= 32'(CHANNELS)) ? CW'(CHANNELS - 1)
	                                                   : CW'(channel_in);

	// read position and fill check of the current line
	assign dly32   = 32'(dly_q[k_q]);
	assign dm      = dly32[AW-1:0];
	assign deff    = (dm == '0) ? MAXD : {1'b0, dm};
	assign rpos    = wp_q[ch_q] - dm;
	assign raddr   = {k_q, ch_q, rpos};
	assign waddr   = {k_q, ch_q, wp_q[ch_q]};
	assign d_gated = vld_q ? rdata_q : '0;

	// stage arithmetic
	assign ap_y   = sat_s(EW'(mx_q) + EW'(d_q));
	assign ap_w   = sat_s(EW'(x_q) - EW'(mul_p));
	assign cb_t   = sat_s(EW'(x_q) + EW'(mul_p));
	assign sum_sh = sum_q >>> 2;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++)
				dly_q[i] <= DLY_RESET[i];
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_GAIN)
				gain_q <= cfg_data[GAIN_W-1:0];
			else if (cfg_index < CFG_IDX_W'(NUM_LINES))
				dly_q[cfg_index[LINE_W-1:0]] <= cfg_data[DLY_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_RD;
			ST_RD:   state_d = ST_WAIT;
			ST_WAIT: state_d = is_ap ? ST_MULX : ST_MULD;
			ST_MULX: if (mul_done) state_d = ST_MULD;
			ST_MULD: if (mul_done) state_d = ST_UPD;
			ST_UPD:  state_d = last_line ? ST_DONE : ST_RD;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		mul_start = 1'b0;
		mul_sel_d = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_RD:   rd_en = 1'b1;
			ST_WAIT: begin
				mul_start = 1'b1;
				mul_sel_d = !is_ap;
			end
			ST_MULX: begin
				mul_start = mul_done;
				mul_sel_d = 1'b1;
			end
			ST_UPD:  wr_en = 1'b1;
			default: ;
		endcase
	end

	// operand: delayed value straight from the read in the comb case
	assign mul_opnd = !mul_sel_d ? x_q : ((state_q == ST_WAIT) ? d_gated : d_q);

	acr_mul #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_opnd),
		.gain    (gain_q),
		.done    (mul_done),
		.product (mul_p)
	);

	// line memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= is_ap ? ap_w : x_q;
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && accept)
				k_q <= '0;
			if (state_q == ST_RD)
				vld_q <= (deff <= cnt_q[ch_q]);
			if (state_q == ST_UPD && !last_line)
				k_q <= k_q + 1'b1;
			if (state_q == ST_DONE && out_free) begin
				wp_q[ch_q]  <= wp_q[ch_q] + 1'b1;
				if (cnt_q[ch_q] != MAXD)
					cnt_q[ch_q] <= cnt_q[ch_q] + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			x_q    <= sample_in;
			ch_q   <= ch_map;
			chin_q <= channel_in;
			sum_q  <= '0;
		end
		if (state_q == ST_WAIT)
			d_q <= d_gated;
		if (state_q == ST_MULX && mul_done)
			mx_q <= mul_p;
		if (state_q == ST_UPD) begin
			if (is_ap)
				x_q <= ap_y;
			else
				sum_q <= sum_q + (SB + 2)'(cb_t);
		end
		if (state_q == ST_DONE && out_free) begin
			sout_q  <= sum_sh[SB-1:0];
			chout_q <= chin_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = chout_q;
	assign sample_out  = sout_q;

	// checks
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the final step");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MULX || state_q == ST_MULD))
		else $error("multiplier finished while not awaited");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= LINE_W'(NUM_LINES - 1)))
		else $error("line index out of range");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (cnt_q[ch_q] <= MAXD))
		else $error("fill count beyond line length");

endmodule
